/* design/gld_pkg.sv */
`default_nettype none

package gld_pkg;

    // Default number of sensors handled by the block.
    localparam int NUM_SENSORS_DEF = 5;

    // Field widths fixed by the stream format.
    localparam int IDX_W   = 3;
    localparam int PPM_W   = 17;
    localparam int THR_W   = 16;
    localparam int CNT_W   = 4;
    localparam int LEVEL_W = 16;
    localparam int ACNT_W  = 3;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register values after reset (10 LEL and 30 LEL, debounce of five readings).
    localparam logic [THR_W-1:0] WARN_THR_RST = 16'd4000;
    localparam logic [THR_W-1:0] ERR_THR_RST  = 16'd12000;
    localparam logic [CNT_W-1:0] HIGHS_RST    = 4'd5;
    localparam logic [CNT_W-1:0] LOWS_RST     = 4'd5;

    // The alarm count field saturates at this value.
    localparam logic [ACNT_W-1:0] ACNT_MAX = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN_THR = 2'd0,
        REG_ERR_THR  = 2'd1,
        REG_HIGHS    = 2'd2,
        REG_LOWS     = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [THR_W-1:0] warn_thr;
        logic [THR_W-1:0] err_thr;
        logic [CNT_W-1:0] highs;
        logic [CNT_W-1:0] lows;
    } t_cfg;

    typedef struct packed {
        logic              sensor_alarm;
        logic [ACNT_W-1:0] alarm_count;
        logic              any_alarm;
        logic              warning;
        logic              notify;
    } t_result;

endpackage

`default_nettype wire

/* design/gas_level_debounced_alarm.sv */
// Debounced gas-level alarm for a bank of hydrogen sensors.
// Readings arrive on the s_axis channel, one item per reading: tdata carries
// the sensor index and the signed ppm value, tuser the disconnected flag.
// A disconnected reading is never high and counts as level zero. Each item yields exactly one
// result item on m_axis: the addressed sensor's alarm, the alarm count,
// the overall alarm, the warning flag and a notify bit for any change of
// the overall flags.
// Thresholds and debounce counts are written through the i_cfg_* port, one register per cycle;
// the user must write them only while no item is in flight; the block does not enforce this.
// Pipeline: an accepted item is captured in an input register, and its result
// is loaded into the result register when the input register advances, that
// is when the result register is empty or its item is taken. Throughput is one
// item per cycle while m_axis does not stall, set by the single update pass
// from the input register into the per-sensor state and the result register.
// When m_axis stalls, the held result stays put and one more item waits in
// the input register; s_axis_tready drops only when both are full.
// Synchronous active-low reset clears the pipeline, restores register
// defaults, zeroes all sensor alarms and run counters, and sets every stored
// level to the disconnected value.
`default_nettype none

module gas_level_debounced_alarm #(
    parameter int NUM_SENSORS = gld_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration writes.
    input  wire logic                             i_cfg_we,
    input  wire logic [gld_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gld_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input items.
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [2:0] sensor_index, [19:3] concentration_ppm, [23:20] zero
    input  wire logic [gld_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] sensor_disconnected
    input  wire logic                             s_axis_tuser,
    // Result items.
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] sensor_alarm, [3:1] alarm_count, [4] any_alarm, [5] warning,
    // [6] notify, [7] zero
    output logic [gld_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import gld_pkg::*;

    t_cfg               r_cfg;

    logic               r_in_valid;
    logic [IDX_W-1:0]   r_idx;
    logic [PPM_W-1:0]   r_ppm;
    logic               r_disc;

    logic               r_out_valid;
    t_result            r_out;

    logic               w_advance;
    logic               w_high;
    logic [LEVEL_W-1:0] w_level;
    logic [NUM_SENSORS-1:0] w_hit;
    logic [NUM_SENSORS-1:0] w_flag_next;
    logic [LEVEL_W-1:0] w_level_next [NUM_SENSORS];
    logic               w_own_alarm;
    t_result            w_result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warn_thr <= WARN_THR_RST;
            r_cfg.err_thr  <= ERR_THR_RST;
            r_cfg.highs    <= HIGHS_RST;
            r_cfg.lows     <= LOWS_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_WARN_THR: r_cfg.warn_thr <= i_cfg_data[THR_W-1:0];
                REG_ERR_THR:  r_cfg.err_thr  <= i_cfg_data[THR_W-1:0];
                REG_HIGHS:    r_cfg.highs    <= i_cfg_data[CNT_W-1:0];
                REG_LOWS:     r_cfg.lows     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result register
    // is empty or its item is taken in this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_idx  <= s_axis_tdata[IDX_W-1:0];
            r_ppm  <= s_axis_tdata[IDX_W +: PPM_W];
            r_disc <= s_axis_tuser;
        end
    end

    // A negative or disconnected level is never high and floors to zero
    // for the warning maximum.
    always_comb begin
        w_high  = !r_disc && !r_ppm[PPM_W-1] && (r_ppm[LEVEL_W-1:0] >= r_cfg.err_thr);
        w_level = (r_disc || r_ppm[PPM_W-1]) ? '0 : r_ppm[LEVEL_W-1:0];
    end

    // One debounce lane per sensor.
    for (genvar k = 0; k < NUM_SENSORS; k++) begin : g_lane
        assign w_hit[k] = w_advance && (32'(r_idx) == k);

        gld_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_upd        (w_hit[k]),
            .i_high       (w_high),
            .i_level      (w_level),
            .i_cfg        (r_cfg),
            .o_flag_next  (w_flag_next[k]),
            .o_level_next (w_level_next[k])
        );
    end

    // An out-of-range index hits no lane and reports no sensor alarm.
    assign w_own_alarm = |(w_hit & w_flag_next);

    gld_summary #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_summary (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_flags     (w_flag_next),
        .i_levels    (w_level_next),
        .i_warn_thr  (r_cfg.warn_thr),
        .i_own_alarm (w_own_alarm),
        .o_result    (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.notify, r_out.warning, r_out.any_alarm,
                            r_out.alarm_count, r_out.sensor_alarm};

`ifndef SYNTHESIS
    a_any_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[3:1] != 3'd0)))
        else $error("any_alarm disagrees with alarm_count");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_advance_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item produced no result");

    a_unknown_sensor_no_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !(|w_hit)) |=> !m_axis_tdata[0])
        else $error("sensor alarm reported for an unknown sensor");
`endif

endmodule

`default_nettype wire

/* design/gld_lane.sv */
`default_nettype none

module gld_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_upd,
    input  wire logic                         i_high,
    input  wire logic [gld_pkg::LEVEL_W-1:0]  i_level,
    input  wire gld_pkg::t_cfg                i_cfg,
    output logic                              o_flag_next,
    output logic [gld_pkg::LEVEL_W-1:0]       o_level_next
);
    import gld_pkg::*;

    logic               r_flag;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0] r_level;

    logic               n_flag;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   w_limit;
    logic [CNT_W-1:0]   w_step;
    logic               w_keeps;
    logic               w_toggle;

    // Debounce: a reading on the side that keeps the flag restarts the run,
    // otherwise the run grows until it reaches the limit and the flag flips.
    always_comb begin
        w_limit  = r_flag ? i_cfg.lows : i_cfg.highs;
        w_keeps  = r_flag ? i_high : !i_high;
        if (w_keeps) begin
            w_step = '0;
        end else if (r_cnt < w_limit) begin
            w_step = r_cnt + CNT_W'(1);
        end else begin
            w_step = r_cnt;
        end
        w_toggle = (w_step >= w_limit);
        n_flag   = w_toggle ? !r_flag : r_flag;
        n_cnt    = w_toggle ? '0 : w_step;
    end

    // The summary sees the values as they stand after this item.
    assign o_flag_next  = i_upd ? n_flag : r_flag;
    assign o_level_next = i_upd ? i_level : r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_cnt   <= '0;
            r_level <= '0;
        end else if (i_upd) begin
            r_flag  <= n_flag;
            r_cnt   <= n_cnt;
            r_level <= i_level;
        end
    end

endmodule

`default_nettype wire

/* design/gld_summary.sv */
`default_nettype none

module gld_summary #(
    parameter int NUM_SENSORS = gld_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_advance,
    input  wire logic [NUM_SENSORS-1:0]      i_flags,
    input  wire logic [gld_pkg::LEVEL_W-1:0] i_levels [NUM_SENSORS],
    input  wire logic [gld_pkg::THR_W-1:0]   i_warn_thr,
    input  wire logic                        i_own_alarm,
    output gld_pkg::t_result                 o_result
);
    import gld_pkg::*;

    localparam int DEPTH  = $clog2(NUM_SENSORS);
    localparam int TREE_N = 1 << DEPTH;
    localparam int CW     = $clog2(NUM_SENSORS + 1);

    logic r_alarm;
    logic r_warning;

    logic [LEVEL_W-1:0] w_tree [DEPTH+1][TREE_N];
    logic [LEVEL_W-1:0] w_max;
    logic [CW-1:0]      w_count;
    logic               n_alarm;
    logic               n_warning;

    // Balanced maximum tree over the floored levels; unused leaves are zero.
    always_comb begin
        for (int d = 0; d <= DEPTH; d++) begin
            for (int i = 0; i < TREE_N; i++) begin
                w_tree[d][i] = '0;
            end
        end
        for (int i = 0; i < NUM_SENSORS; i++) begin
            w_tree[0][i] = i_levels[i];
        end
        for (int d = 1; d <= DEPTH; d++) begin
            for (int i = 0; i < (TREE_N >> d); i++) begin
                w_tree[d][i] = (w_tree[d-1][2*i] > w_tree[d-1][2*i+1]) ?
                               w_tree[d-1][2*i] : w_tree[d-1][2*i+1];
            end
        end
        w_max = w_tree[DEPTH][0];
    end

    // Overall flags; the warning holds when the maximum equals the threshold.
    always_comb begin
        w_count = CW'($countones(i_flags));
        n_alarm = |i_flags;
        if (w_max > i_warn_thr) begin
            n_warning = 1'b1;
        end else if (w_max < i_warn_thr) begin
            n_warning = 1'b0;
        end else begin
            n_warning = r_warning;
        end

        o_result.sensor_alarm = i_own_alarm;
        o_result.alarm_count  = (32'(w_count) > 32'(ACNT_MAX)) ? ACNT_MAX : ACNT_W'(w_count);
        o_result.any_alarm    = n_alarm;
        o_result.warning      = n_warning;
        o_result.notify       = (n_alarm != r_alarm) || (n_warning != r_warning);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm   <= 1'b0;
            r_warning <= 1'b0;
        end else if (i_advance) begin
            r_alarm   <= n_alarm;
            r_warning <= n_warning;
        end
    end

endmodule

`default_nettype wire
